// ----- sv/disk_command_port_controller_macros.svh -----
// Assertion macros for the disk command port controller.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef DISK_COMMAND_PORT_CONTROLLER_MACROS_SVH
`define DISK_COMMAND_PORT_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DCPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("disk command port controller: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DCPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("disk command port controller: next-cycle check failed");

`endif

// ----- sv/dcpc_pkg.sv -----
// Shared types, codes and format tables for the disk command port controller.
// No dependencies; every design file of the block but the macro header uses this package.
package dcpc_pkg;

   localparam int DiskCount = 8;

   // Command codes as they arrive on the port.
   localparam logic [7:0] CMD_NONE  = 8'd0;
   localparam logic [7:0] CMD_READ  = 8'd2;
   localparam logic [7:0] CMD_WRITE = 8'd3;
   localparam logic [7:0] CMD_PARAM = 8'd4;

   // Parameter bytes of a read or write command, in arrival order.
   localparam logic [2:0] POS_DISK     = 3'd0;
   localparam logic [2:0] POS_SECTOR   = 3'd1;
   localparam logic [2:0] POS_TRACK_LO = 3'd2;
   localparam logic [2:0] POS_TRACK_HI = 3'd3;
   localparam logic [2:0] POS_DMA_LO   = 3'd4;
   localparam logic [2:0] POS_DMA_HI   = 3'd5;
   localparam logic [2:0] POS_DONE     = 3'd6;

   // Parameter read sequence positions.
   localparam logic [4:0] PIDX_FIRST_TABLE = 5'd1;
   localparam logic [4:0] PIDX_LAST_TABLE  = 5'd17;
   localparam logic [4:0] PIDX_SIZE_LO     = 5'd18;
   localparam logic [4:0] PIDX_SIZE_HI     = 5'd19;
   localparam logic [4:0] PIDX_MAX         = 5'd31;

   // Status codes.
   localparam logic [7:0] STATUS_OK    = 8'd0;
   localparam logic [7:0] STATUS_ERROR = 8'd1;

   // Configuration register indexes.
   localparam logic [1:0] REG_ATTACHED   = 2'd0;
   localparam logic [1:0] REG_WRITE_LOCK = 2'd1;
   localparam logic [1:0] REG_FORMAT     = 2'd2;

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   // Geometry of the four formats.
   localparam logic [10:0] FMT_SECTOR_SIZE [4] = '{11'd128, 11'd512, 11'd512, 11'd512};
   localparam logic [5:0]  FMT_SPT         [4] = '{6'd32, 6'd8, 6'd18, 6'd9};
   localparam logic [11:0] FMT_TRACKS      [4] = '{12'd2048, 12'd32, 12'd160, 12'd160};

   localparam logic [7:0] FMT_TABLE [4][17] = '{
      '{8'h20, 8'h00, 8'h05, 8'h1F, 8'h01, 8'hF9, 8'h07, 8'hFF, 8'h03,
        8'hFF, 8'h00, 8'h00, 8'h80, 8'h06, 8'h00, 8'h00, 8'h00},
      '{8'h20, 8'h00, 8'h03, 8'h07, 8'h00, 8'h7F, 8'h00, 8'h3E, 8'h00,
        8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h03},
      '{8'h48, 8'h00, 8'h04, 8'h0F, 8'h00, 8'hC6, 8'h02, 8'hFE, 8'h00,
        8'hF0, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h03},
      '{8'h24, 8'h00, 8'h04, 8'h0F, 8'h00, 8'h62, 8'h01, 8'h7E, 8'h00,
        8'hC0, 8'h00, 8'h20, 8'h00, 8'h02, 8'h00, 8'h02, 8'h03}
   };

   typedef struct packed {
      logic       is_out;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        xfer_valid;
      logic        xfer_write;
      logic [2:0]  xfer_disk;
      logic [22:0] xfer_offset;
      logic [15:0] xfer_dma;
      logic [10:0] xfer_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  attached_mask;
      logic [7:0]  write_lock_mask;
      logic [15:0] format_select;
   } cfg_type;

   // Geometry results for the disk currently chosen.
   typedef struct packed {
      logic [7:0]  sector;
      logic [15:0] track;
      logic [22:0] offset;
      logic [10:0] length;
      logic [7:0]  param_byte;
   } geo_type;

endpackage

// ----- sv/disk_command_port_controller.sv -----
// Top level of the disk command port controller: handshakes, result register.
// Depends on dcpc_pkg, dcpc_csr, dcpc_sequencer and the assertion macro header.
//
//   Channel   Direction  Handshake                    Payload
//   req_      in         req_valid / req_ready        dcpc_pkg::req_type (one port access)
//   rsp_      out        rsp_valid / rsp_ready        dcpc_pkg::rsp_type (one result)
//   csr       in         psel, penable, pwrite/pready 32-bit register data
//
// Every port access produces exactly one result, which appears in the result
// register in the cycle after the transfer on the request channel. The command
// registers update at that same edge, so one access per cycle is sustained
// unless the result stalls, which holds the request channel only while the
// single-entry result register is full and rsp_ready is low. Reset is synchronous
// and clears the command state, the configuration and the result valid flag.
`include "disk_command_port_controller_macros.svh"

module disk_command_port_controller #(
   parameter int NumDisks = dcpc_pkg::DiskCount
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dcpc_pkg::req_type                   req_payload,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dcpc_pkg::rsp_type                   rsp_payload,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dcpc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [dcpc_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [dcpc_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready
);

   dcpc_pkg::cfg_type cfg;
   dcpc_pkg::rsp_type result;
   dcpc_pkg::rsp_type rsp_payload_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   // Shorthands for the checks at the end of the module.
   logic              rsp_with_xfer;
   logic              rsp_without_xfer;
   logic              rsp_status_ok;
   logic              rsp_xfer_zero;

   // The result register can take a new transfer whenever it is empty or is
   // being emptied in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   dcpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dcpc_sequencer #(
      .NumDisks (NumDisks)
   ) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload register only loads on a request transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_with_xfer    = rsp_valid_ff && rsp_payload_ff.xfer_valid;
   assign rsp_without_xfer = rsp_valid_ff && !rsp_payload_ff.xfer_valid;
   assign rsp_status_ok    = (rsp_payload_ff.read_data == dcpc_pkg::STATUS_OK);
   assign rsp_xfer_zero    = (rsp_payload_ff.xfer_offset == '0)
                             && (rsp_payload_ff.xfer_length == '0)
                             && (rsp_payload_ff.xfer_dma == '0);

   // A request transfer always leaves a result waiting in the next cycle.
   `DCPC_ASSERT_NEXT(a_transfer_gives_result, accept, rsp_valid_ff)

   // A transfer request always carries the ok status.
   `DCPC_ASSERT_NOW(a_xfer_status_ok, rsp_with_xfer, rsp_status_ok)

   // Without a transfer request the transfer fields stay zero.
   `DCPC_ASSERT_NOW(a_idle_fields_zero, rsp_without_xfer, rsp_xfer_zero)

endmodule

// ----- sv/dcpc_csr.sv -----
// Configuration registers of the disk command port controller, APB-style access.
// Depends on dcpc_pkg.
module dcpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dcpc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [dcpc_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [dcpc_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready,
   output dcpc_pkg::cfg_type                   cfg
);

   dcpc_pkg::cfg_type cfg_ff;
   dcpc_pkg::cfg_type cfg_in;
   logic              write_en;
   logic [1:0]        reg_index;

   assign reg_index = paddr[3:2];
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            dcpc_pkg::REG_ATTACHED:   cfg_in.attached_mask   = pwdata[7:0];
            dcpc_pkg::REG_WRITE_LOCK: cfg_in.write_lock_mask = pwdata[7:0];
            dcpc_pkg::REG_FORMAT:     cfg_in.format_select   = pwdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         dcpc_pkg::REG_ATTACHED:   prdata = {24'd0, cfg_ff.attached_mask};
         dcpc_pkg::REG_WRITE_LOCK: prdata = {24'd0, cfg_ff.write_lock_mask};
         dcpc_pkg::REG_FORMAT:     prdata = {16'd0, cfg_ff.format_select};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/dcpc_geometry.sv -----
// Format geometry: range checks, sector byte offset and parameter bytes.
// Depends on dcpc_pkg; purely combinational.
module dcpc_geometry (
   input  logic [1:0]         fmt,
   input  logic [7:0]         sector,
   input  logic [15:0]        track,
   input  logic [4:0]         param_index,
   output dcpc_pkg::geo_type  geo
);

   logic [10:0] size;
   logic [5:0]  spt;
   logic [11:0] tracks;
   logic [10:0] t;
   logic [4:0]  s;
   logic [15:0] lin;
   logic [4:0]  tbl_idx;

   assign size   = dcpc_pkg::FMT_SECTOR_SIZE[fmt];
   assign spt    = dcpc_pkg::FMT_SPT[fmt];
   assign tracks = dcpc_pkg::FMT_TRACKS[fmt];

   always_comb begin
      geo.sector = (sector >= {2'd0, spt}) ? 8'd0 : sector;
      geo.track  = (track >= {4'd0, tracks}) ? 16'd0 : track;
      geo.length = size;
      // Clamped values fit these widths for every format.
      t = geo.track[10:0];
      s = geo.sector[4:0];

      // Linear sector number: track times sectors per track, by shifts and adds.
      case (fmt)
         2'd0:    lin = {t, 5'd0} + {11'd0, s};
         2'd1:    lin = {2'd0, t, 3'd0} + {11'd0, s};
         2'd2:    lin = {1'd0, t, 4'd0} + {4'd0, t, 1'd0} + {11'd0, s};
         default: lin = {2'd0, t, 3'd0} + {5'd0, t} + {11'd0, s};
      endcase

      if (fmt == 2'd0) begin
         geo.offset = {lin, 7'd0};
      end else begin
         geo.offset = {lin[13:0], 9'd0};
      end

      if (param_index >= dcpc_pkg::PIDX_FIRST_TABLE
          && param_index <= dcpc_pkg::PIDX_LAST_TABLE) begin
         tbl_idx = param_index - 5'd1;
      end else begin
         tbl_idx = 5'd0;
      end

      if (param_index >= dcpc_pkg::PIDX_FIRST_TABLE
          && param_index <= dcpc_pkg::PIDX_LAST_TABLE) begin
         geo.param_byte = dcpc_pkg::FMT_TABLE[fmt][tbl_idx];
      end else if (param_index == dcpc_pkg::PIDX_SIZE_LO) begin
         geo.param_byte = size[7:0];
      end else if (param_index == dcpc_pkg::PIDX_SIZE_HI) begin
         geo.param_byte = {5'd0, size[10:8]};
      end else begin
         geo.param_byte = 8'd0;
      end
   end

endmodule

// ----- sv/dcpc_sequencer.sv -----
// Command sequencer: command and parameter registers, per-access result logic.
// Depends on dcpc_pkg and dcpc_geometry.
module dcpc_sequencer #(
   parameter int NumDisks = dcpc_pkg::DiskCount
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  dcpc_pkg::req_type req,
   input  dcpc_pkg::cfg_type cfg,
   output dcpc_pkg::rsp_type result
);

   logic [7:0]  command_ff, command_in;
   logic [2:0]  position_ff, position_in;
   logic [4:0]  pidx_ff, pidx_in;
   logic [7:0]  disk_ff, disk_in;
   logic [7:0]  sector_ff, sector_in;
   logic [15:0] track_ff, track_in;
   logic [15:0] dma_ff, dma_in;

   logic              is_rw;
   logic              is_wr;
   logic [2:0]        disk_fixed;
   logic [1:0]        fmt;
   logic [4:0]        pidx_next;
   dcpc_pkg::geo_type geo;

   assign is_rw = (command_ff == dcpc_pkg::CMD_READ) || (command_ff == dcpc_pkg::CMD_WRITE);
   assign is_wr = (command_ff == dcpc_pkg::CMD_WRITE);
   // Disk numbers beyond the populated range fall back to disk 0.
   assign disk_fixed = (disk_ff >= 8'(NumDisks)) ? 3'd0 : disk_ff[2:0];
   assign fmt        = cfg.format_select[{disk_fixed, 1'b0} +: 2];
   assign pidx_next  = (pidx_ff == dcpc_pkg::PIDX_MAX) ? pidx_ff : pidx_ff + 5'd1;

   dcpc_geometry u_geometry (
      .fmt         (fmt),
      .sector      (sector_ff),
      .track       (track_ff),
      .param_index (pidx_next),
      .geo         (geo)
   );

   always_comb begin
      command_in  = command_ff;
      position_in = position_ff;
      pidx_in     = pidx_ff;
      disk_in     = disk_ff;
      sector_in   = sector_ff;
      track_in    = track_ff;
      dma_in      = dma_ff;
      result      = '0;

      if (req.is_out) begin
         if (command_ff == dcpc_pkg::CMD_PARAM) begin
            pidx_in = 5'd0;
            disk_in = req.data_in;
         end else if (is_rw) begin
            position_in = position_ff + 3'd1;
            case (position_ff)
               dcpc_pkg::POS_DISK:     disk_in   = req.data_in;
               dcpc_pkg::POS_SECTOR:   sector_in = req.data_in;
               dcpc_pkg::POS_TRACK_LO: track_in  = {8'd0, req.data_in};
               dcpc_pkg::POS_TRACK_HI: track_in  = track_ff + {req.data_in, 8'd0};
               dcpc_pkg::POS_DMA_LO:   dma_in    = {8'd0, req.data_in};
               dcpc_pkg::POS_DMA_HI:   dma_in    = dma_ff + {req.data_in, 8'd0};
               default: begin
                  // A surplus byte drops the command.
                  command_in  = dcpc_pkg::CMD_NONE;
                  position_in = dcpc_pkg::POS_DISK;
               end
            endcase
         end else begin
            command_in  = req.data_in;
            position_in = dcpc_pkg::POS_DISK;
         end
      end else begin
         if (is_rw && position_ff == dcpc_pkg::POS_DONE) begin
            result.read_data = dcpc_pkg::STATUS_ERROR;
            disk_in          = {5'd0, disk_fixed};
            if (cfg.attached_mask[disk_fixed]) begin
               sector_in = geo.sector;
               track_in  = geo.track;
               if (!(is_wr && cfg.write_lock_mask[disk_fixed])) begin
                  result.read_data   = dcpc_pkg::STATUS_OK;
                  result.xfer_valid  = 1'b1;
                  result.xfer_write  = is_wr;
                  result.xfer_disk   = disk_fixed;
                  result.xfer_offset = geo.offset;
                  result.xfer_dma    = dma_ff;
                  result.xfer_length = geo.length;
               end
            end
            command_in  = dcpc_pkg::CMD_NONE;
            position_in = dcpc_pkg::POS_DISK;
         end else if (command_ff == dcpc_pkg::CMD_PARAM) begin
            pidx_in          = pidx_next;
            result.read_data = geo.param_byte;
            if (pidx_next >= dcpc_pkg::PIDX_SIZE_HI) begin
               command_in = dcpc_pkg::CMD_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff  <= dcpc_pkg::CMD_NONE;
         position_ff <= dcpc_pkg::POS_DISK;
         pidx_ff     <= '0;
         disk_ff     <= '0;
         sector_ff   <= '0;
         track_ff    <= '0;
         dma_ff      <= '0;
      end else if (accept) begin
         command_ff  <= command_in;
         position_ff <= position_in;
         pidx_ff     <= pidx_in;
         disk_ff     <= disk_in;
         sector_ff   <= sector_in;
         track_ff    <= track_in;
         dma_ff      <= dma_in;
      end
   end

endmodule

// ----- tb/dcpc_transfer_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the disk command port controller testbench.
// Watches the request, result and configuration ports and predicts every result; needs dcpc_pkg.
module dcpc_transfer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  dcpc_pkg::req_type                 req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  dcpc_pkg::rsp_type                 rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dcpc_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [dcpc_pkg::CsrDataWidth-1:0] pwdata,
   input  logic                              pready,
   output int                                pending_count,
   output int                                fail_count
);

   // Shadow of the configuration registers.
   logic [7:0]  attached_bits;
   logic [7:0]  locked_bits;
   logic [15:0] format_bits;

   // Shadow of the command state.
   logic [7:0]  command;
   logic [2:0]  field_pos;
   logic [4:0]  table_pos;
   logic [7:0]  disk_num;
   logic [7:0]  sector_num;
   logic [15:0] track_num;
   logic [15:0] dma_addr;

   dcpc_pkg::rsp_type expected_results[$];
   int                mismatch_total = 0;

   assign fail_count = mismatch_total;

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
      mismatch_total++;
   endtask

   task automatic compare_result(input dcpc_pkg::rsp_type seen,
                                 input dcpc_pkg::rsp_type wanted);
      if (seen.read_data !== wanted.read_data)
         report_mismatch("read_data", 32'(seen.read_data), 32'(wanted.read_data));
      if (seen.xfer_valid !== wanted.xfer_valid)
         report_mismatch("xfer_valid", 32'(seen.xfer_valid), 32'(wanted.xfer_valid));
      if (seen.xfer_write !== wanted.xfer_write)
         report_mismatch("xfer_write", 32'(seen.xfer_write), 32'(wanted.xfer_write));
      if (seen.xfer_disk !== wanted.xfer_disk)
         report_mismatch("xfer_disk", 32'(seen.xfer_disk), 32'(wanted.xfer_disk));
      if (seen.xfer_offset !== wanted.xfer_offset)
         report_mismatch("xfer_offset", 32'(seen.xfer_offset), 32'(wanted.xfer_offset));
      if (seen.xfer_dma !== wanted.xfer_dma)
         report_mismatch("xfer_dma", 32'(seen.xfer_dma), 32'(wanted.xfer_dma));
      if (seen.xfer_length !== wanted.xfer_length)
         report_mismatch("xfer_length", 32'(seen.xfer_length), 32'(wanted.xfer_length));
   endtask

   // Applies one port access to the shadow state and returns its result.
   task automatic predict_port_access(input dcpc_pkg::req_type acc,
                                      output dcpc_pkg::rsp_type res);
      logic [2:0]  disk;
      logic [1:0]  fmt;
      logic [31:0] offset;
      res = '0;
      if (acc.is_out) begin
         if (command == dcpc_pkg::CMD_PARAM) begin
            table_pos = '0;
            disk_num  = acc.data_in;
         end else if (command == dcpc_pkg::CMD_READ || command == dcpc_pkg::CMD_WRITE) begin
            case (field_pos)
               dcpc_pkg::POS_DISK:     disk_num   = acc.data_in;
               dcpc_pkg::POS_SECTOR:   sector_num = acc.data_in;
               dcpc_pkg::POS_TRACK_LO: track_num  = {8'h00, acc.data_in};
               dcpc_pkg::POS_TRACK_HI: track_num  = track_num + {acc.data_in, 8'h00};
               dcpc_pkg::POS_DMA_LO:   dma_addr   = {8'h00, acc.data_in};
               dcpc_pkg::POS_DMA_HI:   dma_addr   = dma_addr + {acc.data_in, 8'h00};
               default:                command    = dcpc_pkg::CMD_NONE;
            endcase
            // A byte past the last field drops the command.
            if (command == dcpc_pkg::CMD_NONE) field_pos = dcpc_pkg::POS_DISK;
            else field_pos = field_pos + 3'd1;
         end else begin
            command   = acc.data_in;
            field_pos = dcpc_pkg::POS_DISK;
         end
      end else if (field_pos == dcpc_pkg::POS_DONE
                   && (command == dcpc_pkg::CMD_READ || command == dcpc_pkg::CMD_WRITE)) begin
         if (disk_num >= 8'(dcpc_pkg::DiskCount)) disk_num = '0;
         disk = disk_num[2:0];
         res.read_data = dcpc_pkg::STATUS_ERROR;
         if (attached_bits[disk]) begin
            fmt = format_bits[{disk, 1'b0} +: 2];
            if (sector_num >= dcpc_pkg::FMT_SPT[fmt]) sector_num = '0;
            if (track_num >= dcpc_pkg::FMT_TRACKS[fmt]) track_num = '0;
            if (!(command == dcpc_pkg::CMD_WRITE && locked_bits[disk])) begin
               offset = (track_num * dcpc_pkg::FMT_SPT[fmt] + sector_num)
                        * dcpc_pkg::FMT_SECTOR_SIZE[fmt];
               res.read_data   = dcpc_pkg::STATUS_OK;
               res.xfer_valid  = 1'b1;
               res.xfer_write  = (command == dcpc_pkg::CMD_WRITE);
               res.xfer_disk   = disk;
               res.xfer_offset = offset[22:0];
               res.xfer_dma    = dma_addr;
               res.xfer_length = dcpc_pkg::FMT_SECTOR_SIZE[fmt];
            end
         end
         command   = dcpc_pkg::CMD_NONE;
         field_pos = dcpc_pkg::POS_DISK;
      end else if (command == dcpc_pkg::CMD_PARAM) begin
         disk = (disk_num >= 8'(dcpc_pkg::DiskCount)) ? 3'd0 : disk_num[2:0];
         fmt  = format_bits[{disk, 1'b0} +: 2];
         if (table_pos < dcpc_pkg::PIDX_MAX) table_pos = table_pos + 5'd1;
         if (table_pos >= dcpc_pkg::PIDX_SIZE_HI) command = dcpc_pkg::CMD_NONE;
         if (table_pos >= dcpc_pkg::PIDX_FIRST_TABLE && table_pos <= dcpc_pkg::PIDX_LAST_TABLE)
            res.read_data = dcpc_pkg::FMT_TABLE[fmt][table_pos - 5'd1];
         else if (table_pos == dcpc_pkg::PIDX_SIZE_LO)
            res.read_data = dcpc_pkg::FMT_SECTOR_SIZE[fmt][7:0];
         else if (table_pos == dcpc_pkg::PIDX_SIZE_HI)
            res.read_data = {5'd0, dcpc_pkg::FMT_SECTOR_SIZE[fmt][10:8]};
      end
   endtask

   always @(posedge clock) begin
      dcpc_pkg::rsp_type wanted;
      dcpc_pkg::rsp_type predicted;
      if (reset) begin
         attached_bits = '0;
         locked_bits   = '0;
         format_bits   = '0;
         command       = dcpc_pkg::CMD_NONE;
         field_pos     = dcpc_pkg::POS_DISK;
         table_pos     = '0;
         disk_num      = '0;
         sector_num    = '0;
         track_num     = '0;
         dma_addr      = '0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[dcpc_pkg::CsrAddrWidth-1:2])
               dcpc_pkg::REG_ATTACHED:   attached_bits = pwdata[7:0];
               dcpc_pkg::REG_WRITE_LOCK: locked_bits   = pwdata[7:0];
               dcpc_pkg::REG_FORMAT:     format_bits   = pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected",
                               32'(rsp_payload.read_data), 32'd0);
            end else begin
               wanted = expected_results.pop_front();
               compare_result(rsp_payload, wanted);
            end
         end
         if (req_valid && req_ready) begin
            predict_port_access(req_payload, predicted);
            expected_results.push_back(predicted);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ----- tb/tb_disk_command_port_controller.sv -----
`timescale 1ns / 1ps
// Top level of the disk command port controller testbench: clock, reset, stimulus and verdict.
// Needs dcpc_pkg, the block itself and dcpc_transfer_checker.
module tb_disk_command_port_controller;

   // Random traffic per configuration phase; six phases give about 1850 accesses.
   localparam int ItemsPerPhase = 300;
   localparam int PhaseCount    = 6;
   // Each result is registered in the cycle after its transfer, so a short settle tail is plenty.
   localparam int SettleCycles  = 4;
   // Length of the long result stall that fills the block and backs up the requests.
   localparam int HoldCycles    = 300;
   localparam int CycleLimit    = 200000;

   // Ways a read or write command sequence can be laid out on the port.
   typedef enum {SEQ_FULL, SEQ_OVERRUN, SEQ_EARLY_IN, SEQ_SHORT} rw_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid   = 1'b0;
   logic              req_ready;
   dcpc_pkg::req_type req_payload = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dcpc_pkg::rsp_type rsp_payload;

   logic                              psel    = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite  = 1'b0;
   logic [dcpc_pkg::CsrAddrWidth-1:0] paddr   = '0;
   logic [dcpc_pkg::CsrDataWidth-1:0] pwdata  = '0;
   logic [dcpc_pkg::CsrDataWidth-1:0] prdata;
   logic                              pready;

   int pending;
   int failures;

   // Idle rates in percent of cycles for the request and result sides.
   int src_idle_pct  = 24;
   int sink_idle_pct = 48;

   int   items_sent  = 0;
   int   cycle_count = 0;
   int   hold_left   = 0;
   logic hold_arm    = 1'b0;
   logic hold_done   = 1'b0;

   always #5 clock = ~clock;

   disk_command_port_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   dcpc_transfer_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .pending_count (pending),
      .fail_count    (failures)
   );

   // The watchdog ends a run that hangs, for instance on a lost result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The result side stalls at random. Once armed, it holds off for a long
   // stretch a single time, counted here, while the request side keeps
   // offering accesses so that the block fills and stalls its input.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   // Offers one port access and returns at the edge where its transfer takes
   // place. Valid stays high into the next access unless an idle gap is drawn,
   // so it is never lowered and raised in the same step.
   task automatic push_access(input logic write_access, input logic [7:0] value);
      dcpc_pkg::req_type item;
      item.is_out  = write_access;
      item.data_in = value;
      if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < src_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drops valid and waits until every expected result has been checked.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register is written once pready is seen.
   // The trailing cycle keeps back-to-back writes from touching psel twice in one step.
   task automatic csr_write(input logic [1:0] index,
                            input logic [dcpc_pkg::CsrDataWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Disk numbers stay mostly in range, with the rest spread over the whole byte.
   function automatic logic [7:0] pick_disk();
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 7));
      return 8'($urandom_range(0, 255));
   endfunction

   // A read or write command: the command byte, six parameter bytes and the
   // status read. The variants add a byte past the last field, slip in an
   // early status read, or cut the parameter bytes short.
   task automatic rw_sequence(input logic [7:0] cmd, input logic [7:0] disk,
                              input logic [7:0] sector, input logic [15:0] track,
                              input logic [15:0] dma, input rw_shape_type shape);
      logic [7:0] fields [6];
      int         cut;
      int         early;
      fields = '{disk, sector, track[7:0], track[15:8], dma[7:0], dma[15:8]};
      cut    = (shape == SEQ_SHORT) ? $urandom_range(0, 5) : 6;
      early  = $urandom_range(0, 5);
      push_access(1'b1, cmd);
      for (int i = 0; i < cut; i++) begin
         if (shape == SEQ_EARLY_IN && i == early) push_access(1'b0, 8'($urandom));
         push_access(1'b1, fields[i]);
      end
      if (shape == SEQ_OVERRUN) push_access(1'b1, 8'($urandom));
      push_access(1'b0, 8'($urandom));
   endtask

   // A parameter command. An optional run of partial reads is followed by a
   // fresh disk byte, which restarts the table from its first byte.
   task automatic param_sequence(input logic [7:0] disk, input bit with_disk,
                                 input int partial, input int reads);
      push_access(1'b1, dcpc_pkg::CMD_PARAM);
      if (with_disk) push_access(1'b1, disk);
      if (partial != 0) begin
         repeat (partial) push_access(1'b0, 8'($urandom));
         push_access(1'b1, pick_disk());
      end
      repeat (reads) push_access(1'b0, 8'($urandom));
   endtask

   // Mostly well-formed command sequences with random content, and some noise.
   task automatic random_sequence();
      int           pick;
      int           shape_pick;
      rw_shape_type shape;
      logic [7:0]   cmd;
      logic [7:0]   sector;
      logic [15:0]  track;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         cmd        = $urandom_range(0, 1) ? dcpc_pkg::CMD_WRITE : dcpc_pkg::CMD_READ;
         shape_pick = $urandom_range(0, 99);
         if (shape_pick < 85) shape = SEQ_FULL;
         else if (shape_pick < 90) shape = SEQ_OVERRUN;
         else if (shape_pick < 95) shape = SEQ_EARLY_IN;
         else shape = SEQ_SHORT;
         sector = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0:       track = 16'($urandom_range(0, 31));
            1:       track = 16'($urandom_range(0, 159));
            2:       track = 16'($urandom_range(0, 2047));
            default: track = 16'($urandom_range(0, 65535));
         endcase
         rw_sequence(cmd, pick_disk(), sector, track, 16'($urandom), shape);
      end else if (pick < 70) begin
         shape_pick = $urandom_range(0, 99);
         if (shape_pick < 8)
            param_sequence(8'd0, 1'b0, 0, 2);
         else if (shape_pick < 18)
            param_sequence(pick_disk(), 1'b1, $urandom_range(1, 18), 19);
         else if (shape_pick < 28)
            param_sequence(pick_disk(), 1'b1, 0, $urandom_range(20, 22));
         else
            param_sequence(pick_disk(), 1'b1, 0, 19);
      end else if (pick < 80) begin
         // A command byte the block does not act on; the next write replaces it.
         do cmd = 8'($urandom);
         while (cmd == dcpc_pkg::CMD_READ || cmd == dcpc_pkg::CMD_WRITE
                || cmd == dcpc_pkg::CMD_PARAM);
         push_access(1'b1, cmd);
         if ($urandom_range(0, 1)) push_access(1'b0, 8'($urandom));
      end else if (pick < 90) begin
         push_access(1'b0, 8'($urandom));
      end else begin
         push_access(1'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int          phase;
      int          target;
      logic [7:0]  attach_val;
      logic [7:0]  lock_val;
      logic [15:0] format_val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PhaseCount; phase++) begin
         // Settings run from all attached with mixed formats, through the
         // all-clear and all-set extremes and random masks, to all attached and unlocked.
         case (phase)
            0: begin
               attach_val = 8'hFF; lock_val = 8'hF0; format_val = 16'hE4E4;
            end
            1: begin
               attach_val = 8'h00; lock_val = 8'h00; format_val = 16'h0000;
            end
            2: begin
               attach_val = 8'hFF; lock_val = 8'hFF; format_val = 16'hFFFF;
            end
            5: begin
               attach_val = 8'hFF; lock_val = 8'h00; format_val = 16'h1B1B;
            end
            default: begin
               attach_val = 8'($urandom);
               lock_val   = 8'($urandom);
               format_val = 16'($urandom);
            end
         endcase

         // The receiver idles more in the first third, the sender in the
         // second, and neither in the last.
         if (phase < 2) begin
            src_idle_pct = 24;
            sink_idle_pct <= 48;
         end else if (phase < 4) begin
            src_idle_pct = 48;
            sink_idle_pct <= 24;
         end else begin
            src_idle_pct = 0;
            sink_idle_pct <= 0;
         end

         settle();
         csr_write(dcpc_pkg::REG_ATTACHED, {24'd0, attach_val});
         csr_write(dcpc_pkg::REG_WRITE_LOCK, {24'd0, lock_val});
         csr_write(dcpc_pkg::REG_FORMAT, {16'd0, format_val});

         if (phase == 0) begin
            // Status read with no command active.
            push_access(1'b0, 8'hFF);
            // Write to a disk number out of range, which falls back to disk 0,
            // at the last sector of the last track: the largest offset.
            rw_sequence(dcpc_pkg::CMD_WRITE, 8'hFF, 8'd31, 16'd2047, 16'hFFFF, SEQ_FULL);
            // Parameter read for an out-of-range disk answers from disk 0's format.
            param_sequence(8'h08, 1'b1, 0, 19);
         end

         if (phase == 4) hold_arm <= 1'b1;

         target = items_sent + ItemsPerPhase;
         while (items_sent < target) random_sequence();
      end

      settle();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
